/* sv/lb64_pkg.sv */
package lb64_pkg;

  // Characters with special meaning
  localparam logic [7:0] SymPad   = 8'h3D;  // '='
  localparam logic [7:0] SymPlus  = 8'h2B;  // '+'
  localparam logic [7:0] SymMinus = 8'h2D;  // '-'
  localparam logic [7:0] SymSlash = 8'h2F;  // '/'
  localparam logic [7:0] SymUnder = 8'h5F;  // '_'

  localparam logic [5:0] SxtLowerBase = 6'd26;
  localparam logic [5:0] SxtDigitBase = 6'd52;
  localparam logic [5:0] Sxt62        = 6'd62;
  localparam logic [5:0] Sxt63        = 6'd63;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } lb64_sxt_t;

  // One result item
  typedef struct packed {
    logic [15:0] byte_count;
    logic        status;
    logic        final_res;
    logic        is_data;
    logic [7:0]  data_byte;
  } lb64_res_t;

  // Which result slots an item fills
  typedef struct packed {
    logic data_vld;
    logic stat_vld;
  } lb64_push_t;

  function automatic lb64_sxt_t lb64_sextet(input logic [7:0] c);
    lb64_sxt_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61) + SxtLowerBase;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30) + SxtDigitBase;
    end else if (c == SymMinus || c == SymPlus) begin
      r.val = Sxt62;
    end else if (c == SymUnder || c == SymSlash) begin
      r.val = Sxt63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* sv/lb64_core.sv */
module lb64_core
  import lb64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  symbol_i,
  input  logic        eom_i,
  input  logic [15:0] capacity_i,
  output lb64_push_t  push_o,
  output lb64_res_t   data_res_o,
  output lb64_res_t   stat_res_o
);

  logic [11:0] acc_q, acc_d;
  logic [3:0]  pend_q, pend_d;
  logic [15:0] bw_q, bw_d;
  logic        pad_q, pad_d;
  logic        ovf_q, ovf_d;

  lb64_sxt_t   sx;
  logic [11:0] acc6, acc_sh, acc_keep;
  logic [3:0]  pend6, pend8;
  logic [16:0] cap_eff, bw_inc;

  always_comb begin
    sx       = lb64_sextet(symbol_i);
    acc6     = {acc_q[5:0], sx.val};
    pend6    = pend_q + 4'd6;
    pend8    = pend6 - 4'd8;
    acc_sh   = acc6 >> pend8;
    acc_keep = acc6 & ~(12'hFFF << pend8);
    cap_eff  = (capacity_i == '0) ? 17'd1 : {1'b0, capacity_i};
    bw_inc   = {1'b0, bw_q} + 17'd1;

    acc_d  = acc_q;
    pend_d = pend_q;
    bw_d   = bw_q;
    pad_d  = pad_q;
    ovf_d  = ovf_q;
    push_o.data_vld = 1'b0;

    if (!pad_q && !ovf_q) begin
      if (symbol_i == SymPad) begin
        pad_d = 1'b1;
      end else if (sx.ok) begin
        if (pend6 >= 4'd8) begin
          pend_d = pend8;
          if (bw_inc >= cap_eff) begin
            // no room left beside the terminator slot
            ovf_d = 1'b1;
            acc_d = acc6;
          end else begin
            bw_d  = bw_inc[15:0];
            acc_d = acc_keep;
            push_o.data_vld = 1'b1;
          end
        end else begin
          acc_d  = acc6;
          pend_d = pend6;
        end
      end
    end

    push_o.stat_vld = eom_i;

    data_res_o.data_byte  = acc_sh[7:0];
    data_res_o.is_data    = 1'b1;
    data_res_o.final_res  = 1'b0;
    data_res_o.status     = 1'b0;
    data_res_o.byte_count = bw_d;

    stat_res_o.data_byte  = '0;
    stat_res_o.is_data    = 1'b0;
    stat_res_o.final_res  = 1'b1;
    stat_res_o.status     = ovf_d;
    stat_res_o.byte_count = bw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      bw_q   <= '0;
      pad_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      if (eom_i) begin
        acc_q  <= '0;
        pend_q <= '0;
        bw_q   <= '0;
        pad_q  <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        bw_q   <= bw_d;
        pad_q  <= pad_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

/* sv/lb64_queue.sv */
module lb64_queue
  import lb64_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lb64_push_t           push_i,
  input  lb64_res_t            data_res_i,
  input  lb64_res_t            stat_res_i,
  input  logic                 pop_i,
  output lb64_res_t            head_o,
  output logic [QueueCntW-1:0] count_o
);

  lb64_res_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wp1;
  logic [1:0]           n_push;

  assign wp1    = wp_q + QueuePtrW'(1);
  assign n_push = 2'(push_i.data_vld) + 2'(push_i.stat_vld);
  assign cnt_d  = cnt_q + QueueCntW'(n_push) - QueueCntW'(pop_i);

  // data result goes ahead of the status result of the same item
  always_ff @(posedge clk_i) begin
    if (push_i.data_vld) begin
      mem_q[wp_q] <= data_res_i;
      if (push_i.stat_vld) mem_q[wp1] <= stat_res_i;
    end else if (push_i.stat_vld) begin
      mem_q[wp_q] <= stat_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QueuePtrW'(n_push);
      rp_q  <= rp_q + QueuePtrW'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

/* sv/lenient_base64_decoder_unit.sv */
// Channel  | Dir | Handshake          | Contents
// s_axis   | in  | tvalid/tready      | tdata[7:0] symbol, tlast end_of_message
// m_axis   | out | tvalid/tready      | tdata data_byte/status/byte_count, tuser is_data,
//          |     |                    | tlast final_res
// cfg      | in  | cfg_we_i (no wait) | cfg_wdata_i buffer_capacity
//
// One item per cycle is taken while the queue has room for two results. An
// accepted item is held in the input register; the decode step then writes its
// zero, one or two results into a four-entry result queue, and m_axis shows the
// queue head, so the first result shows once the queue holds it. Two results
// leave m_axis one at a time. The input register moves on only while the queue
// has room for two. Reset clears the decode state, the queue and sets capacity to 65535.
module lenient_base64_decoder_unit
  import lb64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] data_byte, [8] status, [24:9] byte_count
  output logic        m_axis_tuser_o,   // is_data
  output logic        m_axis_tlast_o    // final_res
);

  logic [15:0] cap_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_sym_q;
  logic       in_eom_q;

  logic                 advance;
  logic                 s_acc;
  logic                 pop;
  lb64_push_t           push;
  lb64_push_t           push_gated;
  lb64_res_t            data_res, stat_res, head;
  logic [QueueCntW-1:0] q_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // room for a data and a status result
  assign advance         = in_vld_q && (q_cnt <= QueueCntW'(QueueDepth - 2));
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_sym_q <= s_axis_tdata_i;
      in_eom_q <= s_axis_tlast_i;
    end
  end

  lb64_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .symbol_i   (in_sym_q),
    .eom_i      (in_eom_q),
    .capacity_i (cap_q),
    .push_o     (push),
    .data_res_o (data_res),
    .stat_res_o (stat_res)
  );

  assign push_gated.data_vld = push.data_vld && advance;
  assign push_gated.stat_vld = push.stat_vld && advance;

  assign m_axis_tvalid_o = (q_cnt != '0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  lb64_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_gated),
    .data_res_i (data_res),
    .stat_res_i (stat_res),
    .pop_i      (pop),
    .head_o     (head),
    .count_o    (q_cnt)
  );

  assign m_axis_tdata_o = {7'd0, head.byte_count, head.status, head.data_byte};
  assign m_axis_tuser_o = head.is_data;
  assign m_axis_tlast_o = head.final_res;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= QueueCntW'(QueueDepth))
    else $error("result queue over capacity");

  // every result is either data or closing status, never both
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o ^ m_axis_tlast_o))
    else $error("result kind malformed");

  // data results never carry an error status
  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !m_axis_tdata_o[8])
    else $error("status set on data result");

  // input stalls only when the held item cannot move on
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && q_cnt > QueueCntW'(QueueDepth - 2)))
    else $error("input stalled without cause");

endmodule

/* verif/tb_top.sv */
module tb_top;
  import lb64_pkg::*;

  // One input item: a raw character and its end-of-message flag
  typedef struct packed {
    logic [7:0] sym;
    logic       eom;
  } b64_char_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_sym = '0;
  logic        s_eom = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // Pending characters and the decoded results they should produce
  b64_char_t   char_q[$];
  lb64_res_t   decoded_q[$];

  // Shadow of the decoder state
  logic [15:0] cap_shadow = 16'hFFFF;
  logic [11:0] acc_bits = '0;
  logic [3:0]  acc_cnt = '0;
  logic [15:0] msg_bytes = '0;
  logic        pad_hit = 1'b0;
  logic        cap_hit = 1'b0;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 52;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  int unsigned n_errors = 0;
  int unsigned n_data = 0;
  int unsigned n_msgs = 0;
  int unsigned n_ovf = 0;
  int unsigned n_chars = 0;

  string b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";

  lenient_base64_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_sym),
    .s_axis_tlast_i  (s_eom),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // bit 6 = valid, [5:0] = six-bit value
  function automatic logic [6:0] sextet_val(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - 8'h41)};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - 8'h61 + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - 8'h30 + 8'd52)};
    if (c == SymPlus || c == SymMinus) return {1'b1, 6'd62};
    if (c == SymSlash || c == SymUnder) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // Advance the shadow decoder by one character, queue what it emits
  function automatic void decode_char(input logic [7:0] sym, input logic eom);
    logic [6:0]  sx;
    logic [15:0] lim;
    lb64_res_t   r;
    if (!pad_hit && !cap_hit) begin
      if (sym == SymPad) begin
        pad_hit = 1'b1;
      end else begin
        sx = sextet_val(sym);
        if (sx[6]) begin
          acc_bits = {acc_bits[5:0], sx[5:0]};
          acc_cnt  = acc_cnt + 4'd6;
          if (acc_cnt >= 4'd8) begin
            lim = (cap_shadow == 16'd0) ? 16'd1 : cap_shadow;
            acc_cnt = acc_cnt - 4'd8;
            // one slot is kept for the terminator
            if ({1'b0, msg_bytes} + 17'd1 >= {1'b0, lim}) begin
              cap_hit = 1'b1;
            end else begin
              msg_bytes = msg_bytes + 16'd1;
              r = '0;
              r.is_data    = 1'b1;
              r.data_byte  = 8'(acc_bits >> acc_cnt);
              r.byte_count = msg_bytes;
              decoded_q.push_back(r);
              acc_bits = acc_bits & ((12'd1 << acc_cnt) - 12'd1);
            end
          end
        end
      end
    end
    if (eom) begin
      r = '0;
      r.final_res  = 1'b1;
      r.status     = cap_hit;
      r.byte_count = msg_bytes;
      decoded_q.push_back(r);
      acc_bits  = '0;
      acc_cnt   = '0;
      msg_bytes = '0;
      pad_hit   = 1'b0;
      cap_hit   = 1'b0;
    end
  endfunction

  // Driver: keeps valid up while an item waits, predicts on acceptance
  always @(posedge clk_i) begin
    b64_char_t c;
    if (rst_n) begin
      if (s_valid && s_ready) begin
        decode_char(s_sym, s_eom);
        n_chars++;
      end
      if (!s_valid || s_ready) begin
        if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = char_q.pop_front();
          s_valid <= 1'b1;
          s_sym   <= c.sym;
          s_eom   <= c.eom;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction
  always @(posedge clk_i) begin
    lb64_res_t want;
    lb64_res_t got;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        got.data_byte  = m_tdata[7:0];
        got.status     = m_tdata[8];
        got.byte_count = m_tdata[24:9];
        got.is_data    = m_tuser;
        got.final_res  = m_tlast;
        if (decoded_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected result tdata=%h tuser=%b tlast=%b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = decoded_q.pop_front();
          if (got.data_byte !== want.data_byte || got.status !== want.status ||
              got.byte_count !== want.byte_count || got.is_data !== want.is_data ||
              got.final_res !== want.final_res || m_tdata[31:25] !== 7'd0) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"ERROR: exp byte=%h data=%b fin=%b st=%b cnt=%0d",
                        " | got tdata=%h data=%b fin=%b"},
                       want.data_byte, want.is_data, want.final_res, want.status,
                       want.byte_count, m_tdata, m_tuser, m_tlast);
          end
          if (want.is_data) n_data++;
          if (want.final_res) n_msgs++;
          if (want.final_res && want.status) n_ovf++;
        end
      end
      // long hold-off lets the result queue fill and back-pressure the input
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 120;
        m_ready  <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_raw(input logic [7:0] sym, input logic eom);
    b64_char_t c;
    c.sym = sym;
    c.eom = eom;
    char_q.push_back(c);
  endtask

  // Characters of a message that goes on after them
  task automatic queue_open(input string s);
    for (int i = 0; i < s.len(); i++) queue_raw(s[i], 1'b0);
  endtask

  task automatic queue_text(input string s);
    b64_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.sym = s[i];
      c.eom = (i == s.len() - 1);
      char_q.push_back(c);
    end
  endtask

  // Mostly well-formed text with random content; some pure noise
  task automatic queue_message(input int unsigned len);
    b64_char_t   c;
    int unsigned r;
    logic        noisy;
    noisy = ($urandom_range(99) < 12);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (noisy || r < 6) c.sym = 8'($urandom_range(255));
      else if (r < 9 && i + 3 >= len) c.sym = SymPad;
      else c.sym = b64_set[$urandom_range(b64_set.len() - 1)];
      c.eom = (i == len - 1);
      char_q.push_back(c);
    end
  endtask

  // Wait till stimulus is taken and all results are back, then pipeline drain
  task automatic drain();
    while (char_q.size() != 0 || s_valid || decoded_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cap_shadow = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned budget;
    int unsigned len;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed: full groups, both alphabets' 62/63, field extremes, pad, noise
    queue_text("TWFu");
    queue_text("+/-_");
    queue_open("AZaz09");
    queue_raw(8'h00, 1'b0);
    queue_raw(8'hFF, 1'b0);
    queue_text("=Q");
    queue_text("=");
    queue_raw(8'hFF, 1'b1);
    drain();
    // capacity of one: nothing fits
    write_capacity(16'd1);
    queue_text("QUJD");
    drain();
    // capacity of zero acts as one
    write_capacity(16'd0);
    queue_text("QQ==");
    drain();

    // random phases: idling profile changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 52 : 0;
      recv_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 38 : 0;
      case (ph)
        0: write_capacity(16'hFFFF);
        1: write_capacity(16'd3);
        2: write_capacity(16'd2);
        3: write_capacity(16'($urandom_range(40, 4)));
        4: write_capacity(16'd9);
        default: write_capacity(16'($urandom_range(65534, 41)));
      endcase
      budget = 165;
      while (budget > 0) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 21) : $urandom_range(20, 1);
        if (len > budget) len = budget;
        queue_message(len);
        budget -= len;
      end
      if (ph == 1 || ph == 4) begin
        repeat (30) @(negedge clk_i);
        hold_req = 1'b1;
      end
      drain();
    end

    $display("tb: %0d characters in, %0d messages closed (%0d over capacity), %0d bytes",
             n_chars, n_msgs, n_ovf, n_data);
    $display("tb: capacities 0, 1, 2, 3, small, mid and 65535 under three idling profiles");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", n_errors);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
sv/lb64_pkg.sv
sv/lb64_core.sv
sv/lb64_queue.sv
sv/lenient_base64_decoder_unit.sv
verif/tb_top.sv
